@@ rtl/pfsw_pkg.sv @@
// Shared types, codes and helper functions of the page frame buffer span writer.
`timescale 1ns / 1ps
package pfsw_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  localparam int CMD_DEPTH   = 2;
  localparam int RES_DEPTH   = 2;

  localparam logic [2:0] FUNC_SPAN  = 3'd0;
  localparam logic [2:0] FUNC_CLEAR = 3'd1;
  localparam logic [2:0] FUNC_FLUSH = 3'd2;
  localparam logic [2:0] FUNC_READ  = 3'd3;
  localparam logic [2:0] FUNC_MARK  = 3'd4;

  typedef enum logic [2:0] {
    K_NOP   = 3'd0,
    K_SPAN  = 3'd1,
    K_CLEAR = 3'd2,
    K_FLUSH = 3'd3,
    K_READ  = 3'd4,
    K_MARK  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    INK_SET = 2'd0,
    INK_CLR = 2'd1,
    INK_XOR = 2'd2
  } ink_t;

  typedef struct packed {
    kind_t      kind;
    ink_t       ink;
    logic [7:0] col;
    logic [2:0] first_page;
    logic [2:0] last_page;
    logic [2:0] top_bit;
    logic [2:0] bot_bit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] run_first_page;
    logic [2:0] run_last_page;
    logic       no_dirty;
    logic [7:0] read_data;
    logic       applied;
    logic       last;
  } res_t;

  // Bits hi..lo set.
  function automatic logic [7:0] span_mask(logic [2:0] hi, logic [2:0] lo);
    return (8'hFF << hi) & (8'hFF >> (3'd7 - lo));
  endfunction

  function automatic logic [7:0] ink_apply(ink_t ink, logic [7:0] data, logic [7:0] mask);
    logic [7:0] r;
    case (ink)
      INK_CLR: r = data & ~mask;
      INK_XOR: r = data ^ mask;
      default: r = data | mask;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/pfsw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/pfsw_fifo.sv @@
// Small register queue used between front and back and on the result side.
`timescale 1ns / 1ps
module pfsw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/pfsw_front.sv @@
// Front end: accepts commands, clips spans, checks ranges and classifies.
`timescale 1ns / 1ps
module pfsw_front #(
  parameter int COLUMNS = pfsw_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfsw_pkg::PAGES_DEF
) (
  input  logic                push,
  output logic                full,
  input  logic [2:0]          in_func,
  input  logic signed [15:0]  in_span_x,
  input  logic signed [15:0]  in_span_y,
  input  logic [7:0]          in_span_height,
  input  logic [1:0]          in_ink,
  input  logic [7:0]          in_first_page,
  input  logic [7:0]          in_last_page,
  input  logic                cmd_full,
  input  logic                init_busy,
  output logic                cmd_push,
  output pfsw_pkg::cmd_t      cmd
);

  localparam int ROWS = PAGES * 8;

  logic signed [17:0] bottom_s;
  logic               x_ok, top_ok, span_ok, clear_ok, read_ok;
  logic [5:0]         top_c, bot_c;

  assign full     = cmd_full || init_busy;
  assign cmd_push = push && !full;

  assign bottom_s = $signed({{2{in_span_y[15]}}, in_span_y})
                  + $signed({10'd0, in_span_height}) - 18'sd1;
  assign x_ok     = !in_span_x[15] && (in_span_x[14:0] < 15'(COLUMNS));
  assign top_ok   = in_span_y < $signed(16'(ROWS));
  assign span_ok  = (in_span_height != 8'd0) && x_ok && !bottom_s[17] && top_ok;
  assign top_c    = in_span_y[15] ? 6'd0 : in_span_y[5:0];
  assign bot_c    = (bottom_s >= $signed(18'(ROWS))) ? 6'(ROWS - 1) : bottom_s[5:0];
  assign clear_ok = (in_first_page < 8'(PAGES)) && (in_last_page < 8'(PAGES))
                 && (in_first_page <= in_last_page);
  assign read_ok  = x_ok && (in_first_page < 8'(PAGES));

  always_comb begin
    cmd            = '0;
    cmd.kind       = pfsw_pkg::K_NOP;
    cmd.col        = in_span_x[7:0];
    cmd.ink        = (in_ink == 2'd1) ? pfsw_pkg::INK_CLR :
                     (in_ink == 2'd2) ? pfsw_pkg::INK_XOR : pfsw_pkg::INK_SET;
    case (in_func)
      pfsw_pkg::FUNC_SPAN: begin
        if (span_ok) begin
          cmd.kind       = pfsw_pkg::K_SPAN;
          cmd.first_page = top_c[5:3];
          cmd.last_page  = bot_c[5:3];
          cmd.top_bit    = top_c[2:0];
          cmd.bot_bit    = bot_c[2:0];
        end
      end
      pfsw_pkg::FUNC_CLEAR: begin
        if (clear_ok) begin
          cmd.kind       = pfsw_pkg::K_CLEAR;
          cmd.first_page = in_first_page[2:0];
          cmd.last_page  = in_last_page[2:0];
        end
      end
      pfsw_pkg::FUNC_FLUSH: cmd.kind = pfsw_pkg::K_FLUSH;
      pfsw_pkg::FUNC_READ: begin
        if (read_ok) begin
          cmd.kind       = pfsw_pkg::K_READ;
          cmd.first_page = in_first_page[2:0];
        end
      end
      pfsw_pkg::FUNC_MARK: cmd.kind = pfsw_pkg::K_MARK;
      default: cmd.kind = pfsw_pkg::K_NOP;
    endcase
  end

endmodule

@@ rtl/pfsw_back.sv @@
// Back end: frame store, dirty mask, span read-modify-write, clears, flush and reads.
`timescale 1ns / 1ps
module pfsw_back #(
  parameter int COLUMNS = pfsw_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfsw_pkg::PAGES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  pfsw_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output pfsw_pkg::res_t res,
  output logic           init_busy
);

  localparam int DEPTH  = PAGES * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [7:0] PAGE_MASK = 8'((16'd1 << PAGES) - 16'd1);
  localparam logic [2:0] LAST_PG   = 3'(PAGES - 1);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_SPAN  = 7'b0000100,
    ST_CLEAR = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_FLUSH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  pfsw_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [7:0]          dirty_r, dirty_nxt;
  logic [ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [ADDR_W-1:0]   clr_end_r, clr_end_nxt;
  logic [2:0]          rd_page_r, rd_page_nxt;
  logic                rd_more_r, rd_more_nxt;
  logic                wr_v_r, wr_v_nxt;
  logic [2:0]          wr_page_r, wr_page_nxt;
  logic [2:0]          scan_page_r, scan_page_nxt;
  logic                in_run_r, in_run_nxt;
  logic [2:0]          run_start_r, run_start_nxt;
  logic                found_r, found_nxt;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  logic [7:0]          wr_mask;
  logic                scan_bit, scan_next_set, scan_last_run;
  logic [2:0]          scan_start;

  function automatic logic [ADDR_W-1:0] addr_of(logic [2:0] pg, logic [7:0] col);
    return ADDR_W'(32'(pg) * COLUMNS + 32'(col));
  endfunction

  pfsw_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_busy = (state_r == ST_INIT);

  // Partial mask on the edge pages of a span, solid in between.
  assign wr_mask = pfsw_pkg::span_mask(
                     (wr_page_r == cmd_r.first_page) ? cmd_r.top_bit : 3'd0,
                     (wr_page_r == cmd_r.last_page)  ? cmd_r.bot_bit : 3'd7);

  assign scan_bit      = dirty_r[scan_page_r];
  assign scan_next_set = |(dirty_r & PAGE_MASK & (8'h02 << scan_page_r));
  assign scan_last_run = ((dirty_r & PAGE_MASK & (8'hFE << scan_page_r)) == 8'h00);
  assign scan_start    = in_run_r ? run_start_r : scan_page_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    dirty_nxt     = dirty_r;
    clr_addr_nxt  = clr_addr_r;
    clr_end_nxt   = clr_end_r;
    rd_page_nxt   = rd_page_r;
    rd_more_nxt   = rd_more_r;
    wr_v_nxt      = 1'b0;
    wr_page_nxt   = wr_page_r;
    scan_page_nxt = scan_page_r;
    in_run_nxt    = in_run_r;
    run_start_nxt = run_start_r;
    found_nxt     = found_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = '0;
    ram_we        = 1'b0;
    ram_waddr     = clr_addr_r;
    ram_wdata     = 8'h00;
    ram_re        = 1'b0;
    ram_raddr     = addr_of(rd_page_r, cmd_r.col);

    case (state_r)
      ST_INIT: begin
        ram_we = 1'b1;
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          case (cmd.kind)
            pfsw_pkg::K_SPAN: begin
              state_nxt   = ST_SPAN;
              rd_page_nxt = cmd.first_page;
              rd_more_nxt = 1'b1;
            end
            pfsw_pkg::K_CLEAR: begin
              state_nxt    = ST_CLEAR;
              clr_addr_nxt = addr_of(cmd.first_page, 8'd0);
              clr_end_nxt  = ADDR_W'((32'(cmd.last_page) + 1) * COLUMNS - 1);
              dirty_nxt    = dirty_r | pfsw_pkg::span_mask(cmd.first_page, cmd.last_page);
            end
            pfsw_pkg::K_READ: state_nxt = ST_READ;
            pfsw_pkg::K_FLUSH: begin
              state_nxt     = ST_FLUSH;
              scan_page_nxt = 3'd0;
              in_run_nxt    = 1'b0;
              found_nxt     = 1'b0;
            end
            pfsw_pkg::K_MARK: begin
              dirty_nxt = 8'hFF;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SPAN: begin
        // Read the next page while the previous one is written back.
        if (rd_more_r) begin
          ram_re      = 1'b1;
          wr_v_nxt    = 1'b1;
          wr_page_nxt = rd_page_r;
          if (rd_page_r == cmd_r.last_page) begin
            rd_more_nxt = 1'b0;
          end else begin
            rd_page_nxt = rd_page_r + 1'b1;
          end
        end
        if (wr_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = addr_of(wr_page_r, cmd_r.col);
          ram_wdata = pfsw_pkg::ink_apply(cmd_r.ink, ram_rdata, wr_mask);
          dirty_nxt = dirty_r | (8'h01 << wr_page_r);
          if (!rd_more_r) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr_r == clr_end_r) begin
          state_nxt = ST_DONE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_READ: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(cmd_r.first_page, cmd_r.col);
        state_nxt = ST_DONE;
      end
      ST_FLUSH: begin
        // One page per cycle while the result queue has room; a run is reported on its last page.
        if (!res_full) begin
          if (scan_bit) begin
            dirty_nxt = dirty_r & ~(8'h01 << scan_page_r);
            if (!scan_next_set) begin
              res_push           = 1'b1;
              res.run_first_page = scan_start;
              res.run_last_page  = scan_page_r;
              res.last           = scan_last_run;
              found_nxt          = 1'b1;
              in_run_nxt         = 1'b0;
            end else begin
              in_run_nxt    = 1'b1;
              run_start_nxt = scan_start;
            end
          end
          if (scan_page_r == LAST_PG) begin
            if (!scan_bit && !found_r) begin
              res_push     = 1'b1;
              res.no_dirty = 1'b1;
              res.last     = 1'b1;
            end
            state_nxt = ST_IDLE;
          end else begin
            scan_page_nxt = scan_page_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push      = 1'b1;
          res.applied   = (cmd_r.kind == pfsw_pkg::K_SPAN)
                       || (cmd_r.kind == pfsw_pkg::K_CLEAR)
                       || (cmd_r.kind == pfsw_pkg::K_READ);
          res.read_data = (cmd_r.kind == pfsw_pkg::K_READ) ? ram_rdata : 8'h00;
          res.last      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      dirty_r     <= 8'h00;
      clr_addr_r  <= '0;
      rd_more_r   <= 1'b0;
      wr_v_r      <= 1'b0;
      scan_page_r <= 3'd0;
      in_run_r    <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_more_r   <= rd_more_nxt;
      wr_v_r      <= wr_v_nxt;
      scan_page_r <= scan_page_nxt;
      in_run_r    <= in_run_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    clr_end_r   <= clr_end_nxt;
    rd_page_r   <= rd_page_nxt;
    wr_page_r   <= wr_page_nxt;
    run_start_r <= run_start_nxt;
  end

  a_push_has_space: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_wb_only_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    wr_v_r |-> (state_r == ST_SPAN))
    else $error("span write-back pending outside span state");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("store read and write hit the same byte");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FLUSH) && (state_nxt == ST_IDLE)) |=> ((dirty_r & PAGE_MASK) == 8'h00))
    else $error("dirty pages left after flush");

endmodule

@@ rtl/page_framebuffer_span_writer_top.sv @@
// Top level of the page frame buffer span writer: front, command queue, back, result queue.
`timescale 1ns / 1ps
// Span: the store port pair reads page p+1 while page p is written back.
// Clear: one byte written per cycle. Flush: one page scanned per cycle while the result
// queue has room. One command at a time in the back, which stalls while the result
// queue is full. After reset full stays high while the store is zeroed.
module page_framebuffer_span_writer_top #(
  parameter int COLUMNS = pfsw_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfsw_pkg::PAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_func,
  input  logic signed [15:0] in_span_x,
  input  logic signed [15:0] in_span_y,
  input  logic [7:0]         in_span_height,
  input  logic [1:0]         in_ink,
  input  logic [7:0]         in_first_page,
  input  logic [7:0]         in_last_page,
  // result transactions
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_run_first_page,
  output logic [2:0]         out_run_last_page,
  output logic               out_no_dirty,
  output logic [7:0]         out_read_data,
  output logic               out_applied,
  output logic               out_last
);

  // Front to command queue
  logic           cmd_push, cmd_full, init_busy;
  pfsw_pkg::cmd_t cmd_in;
  // Command queue to back
  logic           cmd_empty, cmd_pop;
  pfsw_pkg::cmd_t cmd_head;
  // Back to result queue
  logic           res_push, res_full;
  pfsw_pkg::res_t res_in, res_head;

  // Clip and classify each incoming transaction; hold off during the store sweep.
  pfsw_front #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_front (
    .push           (push),
    .full           (full),
    .in_func        (in_func),
    .in_span_x      (in_span_x),
    .in_span_y      (in_span_y),
    .in_span_height (in_span_height),
    .in_ink         (in_ink),
    .in_first_page  (in_first_page),
    .in_last_page   (in_last_page),
    .cmd_full       (cmd_full),
    .init_busy      (init_busy),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in)
  );

  // Decouple classification from execution so each side stalls on its own.
  pfsw_fifo #(
    .WIDTH ($bits(pfsw_pkg::cmd_t)),
    .DEPTH (pfsw_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  // Execute against the frame store and dirty mask.
  pfsw_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .init_busy (init_busy)
  );

  // Results wait here so the back keeps working while the consumer stalls.
  pfsw_fifo #(
    .WIDTH ($bits(pfsw_pkg::res_t)),
    .DEPTH (pfsw_pkg::RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_run_first_page = res_head.run_first_page;
  assign out_run_last_page  = res_head.run_last_page;
  assign out_no_dirty       = res_head.no_dirty;
  assign out_read_data      = res_head.read_data;
  assign out_applied        = res_head.applied;
  assign out_last           = res_head.last;

endmodule

@@ tb/tb_page_framebuffer_span_writer_top.sv @@
// Self-checking testbench of the page frame buffer span writer, scoreboard class included.
`timescale 1ns / 1ps

// One command transaction as it is driven onto the in_ ports.
typedef struct packed {
  logic [2:0]         func;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic [7:0]         height;
  logic [1:0]         ink;
  logic [7:0]         first_page;
  logic [7:0]         last_page;
} draw_cmd_t;

// Mirror of the frame store and dirty mask; predicts and checks the result transactions.
class frame_mirror;
  localparam int NCOL  = pfsw_pkg::COLUMNS_DEF;
  localparam int NPAGE = pfsw_pkg::PAGES_DEF;
  localparam int NROW  = NPAGE * 8;

  logic [7:0] frame_bytes [NPAGE * NCOL];
  logic [7:0] page_dirty;
  pfsw_pkg::res_t due_reports [$];
  int mismatches;
  int reports_checked;
  int runs_flushed;
  int applied_cmds;

  function new();
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    page_dirty      = 8'h00;
    mismatches      = 0;
    reports_checked = 0;
    runs_flushed    = 0;
    applied_cmds    = 0;
  endfunction

  function int pending();
    return due_reports.size();
  endfunction

  // Apply one accepted command to the mirror and queue the results it causes.
  function void absorb_command(draw_cmd_t c);
    pfsw_pkg::res_t r;
    int sx, top, bottom, pfirst, plast, p, e, hi, lo, idx, runs;
    logic [7:0] mask;
    r  = '0;
    sx = c.x;
    case (c.func)
      pfsw_pkg::FUNC_SPAN: begin
        top    = c.y;
        bottom = top + int'(c.height) - 1;
        if (c.height != 0 && sx >= 0 && sx < NCOL && bottom >= 0 && top < NROW) begin
          if (top < 0) top = 0;
          if (bottom >= NROW) bottom = NROW - 1;
          pfirst = top / 8;
          plast  = bottom / 8;
          for (p = pfirst; p <= plast; p++) begin
            hi = (p == pfirst) ? top % 8 : 0;
            lo = (p == plast) ? bottom % 8 : 7;
            for (int b = 0; b < 8; b++) mask[b] = (b >= hi && b <= lo);
            idx = p * NCOL + sx;
            case (c.ink)
              pfsw_pkg::INK_CLR: frame_bytes[idx] = frame_bytes[idx] & ~mask;
              pfsw_pkg::INK_XOR: frame_bytes[idx] = frame_bytes[idx] ^ mask;
              default:           frame_bytes[idx] = frame_bytes[idx] | mask;
            endcase
            page_dirty[p] = 1'b1;
          end
          r.applied = 1'b1;
        end
        r.last = 1'b1;
        due_reports.push_back(r);
      end
      pfsw_pkg::FUNC_CLEAR: begin
        if (c.first_page < NPAGE && c.last_page < NPAGE && c.first_page <= c.last_page) begin
          for (p = c.first_page; p <= c.last_page; p++) begin
            for (int col = 0; col < NCOL; col++) frame_bytes[p * NCOL + col] = 8'h00;
            page_dirty[p] = 1'b1;
          end
          r.applied = 1'b1;
        end
        r.last = 1'b1;
        due_reports.push_back(r);
      end
      pfsw_pkg::FUNC_FLUSH: begin
        runs = 0;
        p    = 0;
        while (p < NPAGE) begin
          if (!page_dirty[p]) begin
            p++;
            continue;
          end
          e = p;
          while (e + 1 < NPAGE && page_dirty[e + 1]) e++;
          for (int q = p; q <= e; q++) page_dirty[q] = 1'b0;
          if (runs < 4) begin
            r = '0;
            r.run_first_page = p[2:0];
            r.run_last_page  = e[2:0];
            due_reports.push_back(r);
            runs++;
          end
          p = e + 1;
        end
        runs_flushed += runs;
        if (runs == 0) begin
          r = '0;
          r.no_dirty = 1'b1;
          r.last     = 1'b1;
          due_reports.push_back(r);
        end else begin
          due_reports[due_reports.size() - 1].last = 1'b1;
        end
      end
      pfsw_pkg::FUNC_READ: begin
        if (sx >= 0 && sx < NCOL && c.first_page < NPAGE) begin
          r.read_data = frame_bytes[int'(c.first_page) * NCOL + sx];
          r.applied   = 1'b1;
        end
        r.last = 1'b1;
        due_reports.push_back(r);
      end
      default: begin
        if (c.func == pfsw_pkg::FUNC_MARK) page_dirty = 8'hFF;
        r.last = 1'b1;
        due_reports.push_back(r);
      end
    endcase
  endfunction

  function void check_field(string fld, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
      mismatches++;
    end
  endfunction

  // Compare one popped result with the oldest expectation.
  function void compare_report(pfsw_pkg::res_t got);
    pfsw_pkg::res_t want;
    if (due_reports.size() == 0) begin
      $display("%0t: result with none expected, expected nothing, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = due_reports.pop_front();
    reports_checked++;
    if (want.applied) applied_cmds++;
    check_field("run_first_page", 8'(want.run_first_page), 8'(got.run_first_page));
    check_field("run_last_page",  8'(want.run_last_page),  8'(got.run_last_page));
    check_field("no_dirty",       8'(want.no_dirty),       8'(got.no_dirty));
    check_field("read_data",      want.read_data,          got.read_data);
    check_field("applied",        8'(want.applied),        8'(got.applied));
    check_field("last",           8'(want.last),           8'(got.last));
  endfunction
endclass

module tb_page_framebuffer_span_writer_top;

  // Unused command codes and the spare ink code, which the block treats as set.
  localparam logic [2:0] FUNC_RSVD5  = 3'd5;
  localparam logic [2:0] FUNC_RSVD6  = 3'd6;
  localparam logic [2:0] FUNC_RSVD7  = 3'd7;
  localparam logic [1:0] INK_ALT_SET = 2'd3;

  localparam int RANDOM_ITEMS = 402;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {POP_FREE, POP_COIN, POP_SLOW, POP_PERIODIC} pop_mode_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [2:0]         in_func;
  logic signed [15:0] in_span_x;
  logic signed [15:0] in_span_y;
  logic [7:0]         in_span_height;
  logic [1:0]         in_ink;
  logic [7:0]         in_first_page;
  logic [7:0]         in_last_page;
  logic               empty;
  logic               pop;
  logic [2:0]         out_run_first_page;
  logic [2:0]         out_run_last_page;
  logic               out_no_dirty;
  logic [7:0]         out_read_data;
  logic               out_applied;
  logic               out_last;

  frame_mirror mirror;
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          items_sent  = 0;
  pop_mode_t   pop_mode    = POP_FREE;
  int          pop_left    = 0;
  int          pop_phase   = 0;

  page_framebuffer_span_writer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_func            (in_func),
    .in_span_x          (in_span_x),
    .in_span_y          (in_span_y),
    .in_span_height     (in_span_height),
    .in_ink             (in_ink),
    .in_first_page      (in_first_page),
    .in_last_page       (in_last_page),
    .empty              (empty),
    .pop                (pop),
    .out_run_first_page (out_run_first_page),
    .out_run_last_page  (out_run_last_page),
    .out_no_dirty       (out_no_dirty),
    .out_read_data      (out_read_data),
    .out_applied        (out_applied),
    .out_last           (out_last)
  );

  // 20 ns clock, first rising edge at 10 ns.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Guard against a hung block: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, mirror.pending());
      $display("page_framebuffer_span_writer_top test failed");
      $finish;
    end
  end

  // Result side: check every popped transaction, then pick pop for the next edge.
  // The pop pattern switches among free running, coin flips, long stalls and a
  // fixed duty cycle so that stalls land on every phase of a multi-result flush.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        mirror.compare_report({out_run_first_page, out_run_last_page, out_no_dirty,
                               out_read_data, out_applied, out_last});
      if (pop_left == 0) begin
        pop_mode = pop_mode_t'($urandom_range(0, 3));
        pop_left = $urandom_range(16, 96);
      end else begin
        pop_left--;
      end
      pop_phase++;
      case (pop_mode)
        POP_FREE: pop <= 1'b1;
        POP_COIN: pop <= 1'($urandom_range(0, 1));
        POP_SLOW: pop <= ($urandom_range(0, 4) == 0);
        default:  pop <= (pop_phase % 6) < 2;
      endcase
    end
  end

  function automatic draw_cmd_t cmd_of(logic [2:0] func, int x, int y, int h,
                                       logic [1:0] ink, int fp, int lp);
    draw_cmd_t c;
    c.func       = func;
    c.x          = 16'(x);
    c.y          = 16'(y);
    c.height     = 8'(h);
    c.ink        = ink;
    c.first_page = 8'(fp);
    c.last_page  = 8'(lp);
    return c;
  endfunction

  // Mostly well-formed commands inside the panel, some edge values, some pure noise.
  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int pick, sel, fp;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 99);
    c    = cmd_of(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                  2'($urandom), $urandom, $urandom);
    if (pick < 45) begin
      c.func = pfsw_pkg::FUNC_SPAN;
      if (sel < 85)      c.x = 16'($urandom_range(0, 127));
      else if (sel < 93) c.x = 16'(int'($urandom_range(0, 9)) - 5 + (sel % 2) * 128);
      c.y = (sel % 10 < 8) ? 16'(int'($urandom_range(0, 84)) - 10) : 16'($urandom);
      if ($urandom_range(0, 9) < 8) c.height = 8'($urandom_range(1, 20));
    end else if (pick < 63) begin
      c.func = pfsw_pkg::FUNC_READ;
      if (sel < 90) begin
        c.x          = 16'($urandom_range(0, 127));
        c.first_page = 8'($urandom_range(0, 7));
      end
    end else if (pick < 75) begin
      c.func = pfsw_pkg::FUNC_FLUSH;
    end else if (pick < 80) begin
      c.func = pfsw_pkg::FUNC_CLEAR;
      if (sel < 80) begin
        fp           = $urandom_range(0, 7);
        c.first_page = 8'(fp);
        c.last_page  = 8'($urandom_range(fp, (fp < 7) ? fp + 1 : 7));
      end
    end else if (pick < 83) begin
      c.func = pfsw_pkg::FUNC_MARK;
    end else if (pick < 86) begin
      c.func = 3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
    end
    return c;
  endfunction

  // Drive one command, hold it until accepted; drain when asked, else idle at the end of a burst.
  task automatic issue(draw_cmd_t c, bit drain);
    in_func        <= c.func;
    in_span_x      <= c.x;
    in_span_y      <= c.y;
    in_span_height <= c.height;
    in_ink         <= c.ink;
    in_first_page  <= c.first_page;
    in_last_page   <= c.last_page;
    push           <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    mirror.absorb_command(c);
    items_sent++;
    if (drain || burst_left == 0) begin
      push <= 1'b0;
      if (drain) begin
        while (mirror.pending() != 0) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    mirror         = new();
    rst_n          = 1'b0;
    push           = 1'b0;
    in_func        = pfsw_pkg::FUNC_SPAN;
    in_span_x      = '0;
    in_span_y      = '0;
    in_span_height = '0;
    in_ink         = pfsw_pkg::INK_SET;
    in_first_page  = '0;
    in_last_page   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part; the block holds full while it zeroes the store after reset.
    issue(cmd_of(pfsw_pkg::FUNC_READ, 0, 0, 0, pfsw_pkg::INK_SET, 0, 0), 0);   // store clear
    issue(cmd_of(pfsw_pkg::FUNC_FLUSH, 0, 0, 0, pfsw_pkg::INK_SET, 0, 0), 0);  // nothing dirty
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 0, 0, 1, pfsw_pkg::INK_SET, 0, 0), 0);   // single pixel
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 127, -5, 10, pfsw_pkg::INK_XOR, 0, 0), 0); // top clipped
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 64, 60, 255, INK_ALT_SET, 0, 0), 0);  // bottom clipped
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 5, 20, 1, pfsw_pkg::INK_CLR, 0, 0), 0);
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 6, 36, 3, pfsw_pkg::INK_SET, 0, 0), 0);
    issue(cmd_of(pfsw_pkg::FUNC_FLUSH, 0, 0, 0, pfsw_pkg::INK_SET, 0, 0), 0);  // four runs
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, -1, 0, 8, pfsw_pkg::INK_SET, 0, 0), 0);  // off the left
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 128, 0, 8, pfsw_pkg::INK_SET, 0, 0), 0); // off the right
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 32767, -32768, 255, pfsw_pkg::INK_SET, 0, 0), 0);
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 10, -32768, 255, pfsw_pkg::INK_SET, 0, 0), 0); // above
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 10, 64, 1, pfsw_pkg::INK_SET, 0, 0), 0); // just below
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 10, 8, 0, pfsw_pkg::INK_SET, 0, 0), 0);  // zero height
    issue(cmd_of(pfsw_pkg::FUNC_SPAN, 0, 0, 64, pfsw_pkg::INK_XOR, 0, 0), 0);  // every page
    issue(cmd_of(pfsw_pkg::FUNC_READ, 127, 0, 0, pfsw_pkg::INK_SET, 0, 0), 0);
    issue(cmd_of(pfsw_pkg::FUNC_READ, 64, 0, 0, pfsw_pkg::INK_SET, 7, 0), 0);
    issue(cmd_of(pfsw_pkg::FUNC_READ, 0, 0, 0, pfsw_pkg::INK_SET, 8, 0), 0);   // bad page
    issue(cmd_of(pfsw_pkg::FUNC_READ, -32768, 0, 0, pfsw_pkg::INK_SET, 255, 0), 0);
    issue(cmd_of(pfsw_pkg::FUNC_CLEAR, 0, 0, 0, pfsw_pkg::INK_SET, 3, 2), 0);  // reversed
    issue(cmd_of(pfsw_pkg::FUNC_CLEAR, 0, 0, 0, pfsw_pkg::INK_SET, 8, 8), 0);
    issue(cmd_of(pfsw_pkg::FUNC_CLEAR, 0, 0, 0, pfsw_pkg::INK_SET, 0, 255), 0);
    issue(cmd_of(pfsw_pkg::FUNC_CLEAR, 0, 0, 0, pfsw_pkg::INK_SET, 0, 7), 0);  // whole store
    issue(cmd_of(pfsw_pkg::FUNC_FLUSH, 0, 0, 0, pfsw_pkg::INK_SET, 0, 0), 0);  // one long run
    issue(cmd_of(pfsw_pkg::FUNC_MARK, 0, 0, 0, pfsw_pkg::INK_SET, 0, 0), 0);
    issue(cmd_of(FUNC_RSVD5, $urandom, $urandom, $urandom, 2'($urandom), $urandom, $urandom), 0);
    issue(cmd_of(FUNC_RSVD6, $urandom, $urandom, $urandom, 2'($urandom), $urandom, $urandom), 0);
    issue(cmd_of(FUNC_RSVD7, $urandom, $urandom, $urandom, 2'($urandom), $urandom, $urandom), 1);

    // Random part; drain midway and at the end so the block empties out completely.
    for (int n = 0; n < RANDOM_ITEMS; n++)
      issue(random_cmd(), n == RANDOM_ITEMS / 2 || n == RANDOM_ITEMS - 1);

    // Allow any stray result to show up before the verdict.
    repeat (40) @(posedge clk);

    $display("Covered %0d commands: %0d results checked, %0d dirty runs flushed, %0d applied.",
             items_sent, mirror.reports_checked, mirror.runs_flushed, mirror.applied_cmds);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("page_framebuffer_span_writer_top test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", mirror.mismatches, mirror.pending());
      $display("page_framebuffer_span_writer_top test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pfsw_pkg.sv
rtl/pfsw_ram.sv
rtl/pfsw_fifo.sv
rtl/pfsw_front.sv
rtl/pfsw_back.sv
rtl/page_framebuffer_span_writer_top.sv
tb/tb_page_framebuffer_span_writer_top.sv
